// ----- src/owsd_pkg.sv -----
`timescale 1ns / 1ps
// Package for the single-wire sensor pulse decoder: item types, register map,
// timing windows and frame constants. No dependencies.
package owsd_pkg;

    localparam int TIME_WIDTH  = 16;
    localparam int COUNT_WIDTH = 6;
    localparam int FRAME_BITS  = 40;
    localparam int BYTE_WIDTH  = 8;
    localparam int ADDR_WIDTH  = 4;
    localparam int DATA_WIDTH  = 32;
    localparam int TICK_WIDTH  = 16;

    localparam logic [COUNT_WIDTH-1:0] FIRST_DATA_EDGE = COUNT_WIDTH'(2);
    localparam logic [COUNT_WIDTH-1:0] LAST_EDGE_INDEX = COUNT_WIDTH'(41);

    localparam logic [TICK_WIDTH-1:0] ZERO_MIN_RESET = TICK_WIDTH'(70);
    localparam logic [TICK_WIDTH-1:0] ZERO_MAX_RESET = TICK_WIDTH'(85);
    localparam logic [TICK_WIDTH-1:0] ONE_MIN_RESET  = TICK_WIDTH'(116);
    localparam logic [TICK_WIDTH-1:0] ONE_MAX_RESET  = TICK_WIDTH'(150);

    typedef enum logic [1:0] {
        REG_ZERO_MIN = 2'd0,
        REG_ZERO_MAX = 2'd1,
        REG_ONE_MIN  = 2'd2,
        REG_ONE_MAX  = 2'd3
    } reg_index_t;

    typedef struct packed {
        logic                  frame_start;
        logic [TIME_WIDTH-1:0] edge_time;
    } in_item_t;

    typedef struct packed {
        logic [15:0] humidity_raw;
        logic [15:0] temperature_raw;
        logic        checksum_ok;
    } out_item_t;

endpackage

// ----- src/one_wire_sensor_pulse_decoder_top.sv -----
`timescale 1ns / 1ps
// Top level of the single-wire sensor pulse decoder: input register, frame
// decode logic, result register and APB register bank. Depends on owsd_pkg.

// One item is taken per cycle when the result side is not stalled. Each item
// is either a frame start, which re-arms the receiver, or the timer value
// captured at a falling edge of the sensor line. An accepted item is held in
// the input register, and its result, if any, is loaded into the result
// register when the item moves on and raises out_valid. The input register
// only holds while a result waits in the output register and the item it
// holds would give another one; all other items pass at full rate.
// After reset the receiver ignores edges until a frame start arrives. The
// first two captures of a frame are the sensor's response pulses; the next forty
// intervals are classified against the zero and one windows (zero window wins
// where they overlap, an interval in neither reads as 0), and the 42nd capture
// gives one result item with humidity, temperature and the checksum flag. Write
// the window registers only while the block is idle.
module one_wire_sensor_pulse_decoder_top
    import owsd_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    // edge capture items
    input  logic                  in_valid,
    output logic                  in_stall,
    input  in_item_t              in_item,
    // decoded frame items
    output logic                  out_valid,
    input  logic                  out_stall,
    output out_item_t             out_item,
    // configuration
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [ADDR_WIDTH-1:0] paddr,
    input  logic [DATA_WIDTH-1:0] pwdata,
    output logic [DATA_WIDTH-1:0] prdata,
    output logic                  pready
);

    // Window registers
    logic [TICK_WIDTH-1:0] zero_min_reg;
    logic [TICK_WIDTH-1:0] zero_max_reg;
    logic [TICK_WIDTH-1:0] one_min_reg;
    logic [TICK_WIDTH-1:0] one_max_reg;

    // Input register
    logic     s1_valid_reg;
    logic     s1_valid_next;
    in_item_t s1_item_reg;

    // Frame state
    logic [TIME_WIDTH-1:0]  last_edge_reg;
    logic [TIME_WIDTH-1:0]  last_edge_next;
    logic [COUNT_WIDTH-1:0] edge_count_reg;
    logic [COUNT_WIDTH-1:0] edge_count_next;
    logic [FRAME_BITS-1:0]  frame_bits_reg;
    logic [FRAME_BITS-1:0]  frame_bits_next;
    logic                   frame_done_reg;
    logic                   frame_done_next;

    // Result register
    logic      out_valid_reg;
    logic      out_valid_next;
    out_item_t out_item_reg;
    out_item_t out_item_next;

    logic                  in_accept;
    logic                  s1_fire;
    logic                  s1_result;
    logic [TIME_WIDTH-1:0] interval;
    logic                  in_zero;
    logic                  in_one;
    logic                  bit_value;
    logic [BYTE_WIDTH-1:0] byte_sum;
    logic                  cfg_write;
    reg_index_t            cfg_index;

    // ---------------------------------------------------------------
    // Configuration port
    // ---------------------------------------------------------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign cfg_index = reg_index_t'(paddr[3:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            zero_min_reg <= ZERO_MIN_RESET;
            zero_max_reg <= ZERO_MAX_RESET;
            one_min_reg  <= ONE_MIN_RESET;
            one_max_reg  <= ONE_MAX_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_ZERO_MIN: zero_min_reg <= pwdata[TICK_WIDTH-1:0];
                REG_ZERO_MAX: zero_max_reg <= pwdata[TICK_WIDTH-1:0];
                REG_ONE_MIN:  one_min_reg  <= pwdata[TICK_WIDTH-1:0];
                REG_ONE_MAX:  one_max_reg  <= pwdata[TICK_WIDTH-1:0];
                default:      ;
            endcase
        end
    end

    always_comb
    begin
        prdata = '0;
        unique case (cfg_index)
            REG_ZERO_MIN: prdata = DATA_WIDTH'(zero_min_reg);
            REG_ZERO_MAX: prdata = DATA_WIDTH'(zero_max_reg);
            REG_ONE_MIN:  prdata = DATA_WIDTH'(one_min_reg);
            REG_ONE_MAX:  prdata = DATA_WIDTH'(one_max_reg);
            default:      prdata = '0;
        endcase
    end

    // ---------------------------------------------------------------
    // Handshake: the held item moves on unless it would produce a result
    // while the result register is still full and stalled.
    // ---------------------------------------------------------------
    assign s1_result = s1_valid_reg && !s1_item_reg.frame_start && !frame_done_reg
                       && (edge_count_reg >= LAST_EDGE_INDEX);
    assign s1_fire   = s1_valid_reg && !(s1_result && out_valid_reg && out_stall);
    assign in_stall  = s1_valid_reg && !s1_fire;
    assign in_accept = in_valid && !in_stall;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_fire)
        begin
            s1_valid_next = 1'b0;
        end
    end

    // ---------------------------------------------------------------
    // Decode: interval, window match, shift and frame completion
    // ---------------------------------------------------------------
    assign interval  = s1_item_reg.edge_time - last_edge_reg;
    assign in_zero   = (interval >= zero_min_reg) && (interval <= zero_max_reg);
    assign in_one    = (interval >= one_min_reg) && (interval <= one_max_reg);
    // zero window takes priority, and no match reads as zero
    assign bit_value = !in_zero && in_one;

    always_comb
    begin
        last_edge_next  = last_edge_reg;
        edge_count_next = edge_count_reg;
        frame_bits_next = frame_bits_reg;
        frame_done_next = frame_done_reg;
        if (s1_fire)
        begin
            if (s1_item_reg.frame_start)
            begin
                last_edge_next  = '0;
                edge_count_next = '0;
                frame_bits_next = '0;
                frame_done_next = 1'b0;
            end
            else if (!frame_done_reg)
            begin
                last_edge_next = s1_item_reg.edge_time;
                if (edge_count_reg >= FIRST_DATA_EDGE)
                begin
                    frame_bits_next = {frame_bits_reg[FRAME_BITS-2:0], bit_value};
                end
                if (edge_count_reg < LAST_EDGE_INDEX)
                begin
                    edge_count_next = edge_count_reg + 1'b1;
                end
                else
                begin
                    frame_done_next = 1'b1;
                end
            end
        end
    end

    // Bytes of the completed frame, taken from the shifted value
    assign byte_sum = frame_bits_next[39:32] + frame_bits_next[31:24]
                    + frame_bits_next[23:16] + frame_bits_next[15:8];

    always_comb
    begin
        out_item_next  = out_item_reg;
        out_valid_next = out_valid_reg && out_stall;
        if (s1_fire && s1_result)
        begin
            out_valid_next                = 1'b1;
            out_item_next.humidity_raw    = frame_bits_next[39:24];
            out_item_next.temperature_raw = frame_bits_next[23:8];
            out_item_next.checksum_ok     = (byte_sum == frame_bits_next[7:0]);
        end
    end

    // ---------------------------------------------------------------
    // Registers
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            last_edge_reg  <= '0;
            edge_count_reg <= '0;
            frame_bits_reg <= '0;
            frame_done_reg <= 1'b1;
        end
        else
        begin
            s1_valid_reg   <= s1_valid_next;
            out_valid_reg  <= out_valid_next;
            last_edge_reg  <= last_edge_next;
            edge_count_reg <= edge_count_next;
            frame_bits_reg <= frame_bits_next;
            frame_done_reg <= frame_done_next;
        end
    end

    // Payload: hold while stalled, load on acceptance
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_item_reg <= in_item;
        end
        out_item_reg <= out_item_next;
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

endmodule

// ----- test/one_wire_sensor_pulse_decoder_top_test.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for the single-wire sensor pulse decoder: sends edge and
// frame-start items, predicts each decoded frame and checks every result item.
// Depends on owsd_pkg and one_wire_sensor_pulse_decoder_top.
module one_wire_sensor_pulse_decoder_top_test;
    import owsd_pkg::*;

    localparam int MAX_GAP       = 14;
    // Margin after the last owed result, so that items giving no result can clear.
    localparam int SETTLE_CYCLES = 4;
    localparam int TARGET_ITEMS  = 1250;
    localparam int LONG_HOLD     = 400;

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_stall;
    in_item_t              in_item;
    logic                  out_valid;
    logic                  out_stall;
    out_item_t             out_item;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [ADDR_WIDTH-1:0] paddr;
    logic [DATA_WIDTH-1:0] pwdata;
    logic [DATA_WIDTH-1:0] prdata;
    logic                  pready;

    // Receiver state as the decoder should hold it, plus its window registers.
    logic [TIME_WIDTH-1:0]  last_edge;
    logic [COUNT_WIDTH-1:0] edges_seen;
    logic [FRAME_BITS-1:0]  shift_bits;
    logic                   frame_closed;
    logic [TICK_WIDTH-1:0]  zero_lo;
    logic [TICK_WIDTH-1:0]  zero_hi;
    logic [TICK_WIDTH-1:0]  one_lo;
    logic [TICK_WIDTH-1:0]  one_hi;

    // Decoded frames still owed by the block, oldest first.
    out_item_t decoded_q[$];
    out_item_t want;

    int fail_count;
    int live_items;
    bit tx_idle;
    bit rx_idle;
    int hold_request;
    int stall_left;
    int hold_left;

    one_wire_sensor_pulse_decoder_top dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_item  (in_item),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_item (out_item),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial clk = 1'b0;
    always #4 clk = ~clk;

    // Classify one interval: the zero window is tried first, so it wins where the
    // windows overlap; an interval in neither window, or only in an inverted
    // window, reads as 0.
    function automatic logic bit_of_interval(input logic [TIME_WIDTH-1:0] span);
        if (span >= zero_lo && span <= zero_hi)
            return 1'b0;
        if (span >= one_lo && span <= one_hi)
            return 1'b1;
        return 1'b0;
    endfunction

    // Advance the expected receiver state by one accepted item and queue the
    // decoded frame when the edge at LAST_EDGE_INDEX closes it.
    task automatic decode_edge_item(input in_item_t it);
        logic [TIME_WIDTH-1:0] span;
        logic [7:0]            b0, b1, b2, b3, b4, sum;
        out_item_t             res;
        if (it.frame_start)
        begin
            last_edge    = '0;
            edges_seen   = '0;
            shift_bits   = '0;
            frame_closed = 1'b0;
            live_items++;
        end
        else if (!frame_closed)
        begin
            live_items++;
            // Interval wraps modulo the timer width by plain subtraction.
            span      = it.edge_time - last_edge;
            last_edge = it.edge_time;
            // Edges before FIRST_DATA_EDGE are response pulses: no bit shifted in.
            if (edges_seen >= FIRST_DATA_EDGE)
                shift_bits = {shift_bits[FRAME_BITS-2:0], bit_of_interval(span)};
            if (edges_seen < LAST_EDGE_INDEX)
                edges_seen = edges_seen + 1'b1;
            else
            begin
                frame_closed = 1'b1;
                b0  = shift_bits[39:32];
                b1  = shift_bits[31:24];
                b2  = shift_bits[23:16];
                b3  = shift_bits[15:8];
                b4  = shift_bits[7:0];
                sum = b0 + b1 + b2 + b3;
                res.humidity_raw    = {b0, b1};
                res.temperature_raw = {b2, b3};
                res.checksum_ok     = (sum == b4);
                decoded_q.push_back(res);
            end
        end
    endtask

    // Pick an edge interval that lands in the window for the wanted bit, or a
    // wild one at the given rate, or where that window is inverted.
    function automatic logic [TIME_WIDTH-1:0] pick_interval(input logic b, input int noise_pct);
        if ($urandom_range(99, 0) < noise_pct)
            return TIME_WIDTH'($urandom);
        if (b && one_lo <= one_hi)
            return TIME_WIDTH'($urandom_range(one_hi, one_lo));
        if (!b && zero_lo <= zero_hi)
            return TIME_WIDTH'($urandom_range(zero_hi, zero_lo));
        return TIME_WIDTH'($urandom);
    endfunction

    // Four random data bytes followed by a checksum byte, right or random.
    function automatic logic [FRAME_BITS-1:0] frame_payload(input bit good_sum);
        logic [31:0] body;
        logic [7:0]  sum;
        body = $urandom;
        sum  = body[31:24] + body[23:16] + body[15:8] + body[7:0];
        return {body, good_sum ? sum : 8'($urandom)};
    endfunction

    // Offer one item after a random gap and hold it until it is taken. Valid is
    // only dropped when a gap is drawn, so back-to-back items keep it high.
    task automatic send_item(input in_item_t it);
        int gap;
        gap = tx_idle ? $urandom_range(MAX_GAP, 0) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        do
            @(posedge clk);
        while (in_stall);
        decode_edge_item(it);
    endtask

    // Stop offering items until every owed frame has arrived, then let any
    // item that gives no result clear the pipeline.
    task automatic wait_drained;
        in_valid <= 1'b0;
        while (decoded_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // APB write of one window register, then a read back of the same register.
    task automatic write_reg(input reg_index_t idx, input logic [TICK_WIDTH-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_WIDTH'(4 * int'(idx));
        pwdata  <= DATA_WIDTH'(value);
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        case (idx)
            REG_ZERO_MIN: zero_lo = value;
            REG_ZERO_MAX: zero_hi = value;
            REG_ONE_MIN:  one_lo  = value;
            REG_ONE_MAX:  one_hi  = value;
            default: ;
        endcase
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if (prdata[TICK_WIDTH-1:0] !== value)
        begin
            $display("%0t: register %s read back: expected %h, actual %h",
                     $time, idx.name(), value, prdata[TICK_WIDTH-1:0]);
            fail_count++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_windows(input logic [TICK_WIDTH-1:0] zl, input logic [TICK_WIDTH-1:0] zh,
                               input logic [TICK_WIDTH-1:0] ol, input logic [TICK_WIDTH-1:0] oh);
        wait_drained;
        write_reg(REG_ZERO_MIN, zl);
        write_reg(REG_ZERO_MAX, zh);
        write_reg(REG_ONE_MIN, ol);
        write_reg(REG_ONE_MAX, oh);
    endtask

    // Frame start, two response pulses, then one edge per data bit, most
    // significant first. An n_edges short of a full frame leaves it cut short.
    task automatic send_frame(input logic [FRAME_BITS-1:0] payload, input int n_edges,
                              input int noise_pct);
        logic [TIME_WIDTH-1:0] stamp;
        logic [TIME_WIDTH-1:0] span;
        int                    i;
        stamp = $urandom;
        send_item(in_item_t'({1'b1, TIME_WIDTH'($urandom)}));
        for (i = 0; i < n_edges; i++)
        begin
            if (i < 2)
                span = TIME_WIDTH'($urandom_range(160, 60));
            else
                span = pick_interval(payload[6'(41 - i)], noise_pct);
            stamp = stamp + span;
            send_item(in_item_t'({1'b0, stamp}));
        end
    endtask

    // Out of reset the receiver waits for a frame start: edges are ignored.
    task automatic test_edges_before_start;
        send_item(in_item_t'({1'b0, 16'h0000}));
        send_item(in_item_t'({1'b0, 16'hFFFF}));
        send_item(in_item_t'({1'b0, TIME_WIDTH'($urandom)}));
    endtask

    // Intervals on and just outside every window edge, the extremes 0 and
    // all-ones, and a timer that wraps mid-frame; then edges after the frame
    // closed, a restart mid-frame and all-ones and all-zero payloads.
    task automatic test_boundary_frame;
        logic [TIME_WIDTH-1:0] bounds [10];
        logic [TIME_WIDTH-1:0] stamp;
        int                    i;
        bounds = '{ZERO_MIN_RESET, ZERO_MAX_RESET, ONE_MIN_RESET, ONE_MAX_RESET,
                   ZERO_MIN_RESET - 1'b1, ZERO_MAX_RESET + 1'b1,
                   ONE_MIN_RESET - 1'b1, ONE_MAX_RESET + 1'b1, 16'h0000, 16'hFFFF};
        stamp = 16'hFF00;
        send_item(in_item_t'({1'b1, 16'hFFFF}));
        for (i = 0; i < 42; i++)
        begin
            stamp = stamp + ((i < 2) ? TIME_WIDTH'(80) : bounds[4'((i - 2) % 10)]);
            send_item(in_item_t'({1'b0, stamp}));
        end
        send_item(in_item_t'({1'b0, stamp + 16'd100}));
        send_item(in_item_t'({1'b0, TIME_WIDTH'($urandom)}));
        send_frame(frame_payload(1'b1), 12, 0);
        send_frame(40'hFF_FFFF_FFFF, 42, 0);
        send_frame(40'h00_0000_0000, 42, 0);
    endtask

    // Window settings at the extremes: single-value windows at 0 and all-ones,
    // overlapping windows, inverted windows and a zero window that covers all.
    task automatic test_window_extremes;
        set_windows(16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF);
        send_frame(frame_payload(1'b1), 42, 0);
        set_windows(16'hFFFF, 16'hFFFF, 16'h0000, 16'hFFFF);
        send_frame(frame_payload(1'b1), 42, 10);
        set_windows(16'd200, 16'd100, 16'd50, 16'd300);
        send_frame(frame_payload(1'b1), 42, 0);
        set_windows(16'd500, 16'd400, 16'd900, 16'd800);
        send_frame(frame_payload(1'b0), 42, 0);
        set_windows(16'h0000, 16'hFFFF, 16'd100, 16'd200);
        send_frame(frame_payload(1'b1), 42, 0);
        set_windows(ZERO_MIN_RESET, ZERO_MAX_RESET, ONE_MIN_RESET, ONE_MAX_RESET);
    endtask

    // Hold the result side off for a long stretch while frames stream in at
    // full rate, so both registers fill and the block stalls its input.
    task automatic test_backpressure;
        tx_idle      = 1'b0;
        hold_request = LONG_HOLD;
        repeat (3) send_frame(frame_payload(1'b1), 42, 0);
        wait_drained;
        tx_idle = 1'b1;
        rx_idle = 1'b1;
    endtask

    // Mostly well-formed frames with random content and windows; the rest cut
    // frames, stray edges after a frame and raw noise items.
    task automatic test_random_traffic;
        int phase;
        int kind;
        phase = 0;
        while (live_items < TARGET_ITEMS)
        begin
            if (phase % 5 == 4)
            begin
                kind = $urandom_range(2, 0);
                if (kind == 0)
                begin
                    zero_lo = TICK_WIDTH'($urandom_range(80, 40));
                    zero_hi = zero_lo + TICK_WIDTH'($urandom_range(40, 0));
                    one_lo  = zero_hi + TICK_WIDTH'($urandom_range(40, 1));
                    one_hi  = one_lo + TICK_WIDTH'($urandom_range(60, 0));
                    set_windows(zero_lo, zero_hi, one_lo, one_hi);
                end
                else if (kind == 1)
                    set_windows(TICK_WIDTH'($urandom), TICK_WIDTH'($urandom),
                                TICK_WIDTH'($urandom), TICK_WIDTH'($urandom));
                else
                    set_windows(ZERO_MIN_RESET, ZERO_MAX_RESET, ONE_MIN_RESET, ONE_MAX_RESET);
            end
            tx_idle = ($urandom_range(3, 0) != 0);
            rx_idle = ($urandom_range(3, 0) != 0);
            repeat (3)
            begin
                kind = $urandom_range(9, 0);
                if (kind < 7)
                    send_frame(frame_payload($urandom_range(9, 0) < 7), 42,
                               ($urandom_range(1, 0) != 0) ? 0 : 3);
                else if (kind == 7)
                    send_frame(frame_payload(1'b1), $urandom_range(41, 0), 5);
                else if (kind == 8)
                begin
                    send_frame(frame_payload(1'b1), 42, 0);
                    repeat ($urandom_range(3, 1))
                        send_item(in_item_t'({1'b0, TIME_WIDTH'($urandom)}));
                end
                else
                    repeat ($urandom_range(6, 1))
                        send_item(in_item_t'({1'($urandom), TIME_WIDTH'($urandom)}));
            end
            phase++;
        end
    endtask

    // Result side: after each result is taken, draw how many cycles the next
    // one waits while offered. A long hold, when asked for, counts every cycle.
    initial
    begin
        out_stall  = 1'b0;
        stall_left = 0;
        hold_left  = 0;
        forever
        begin
            @(posedge clk);
            if (out_valid && !out_stall)
                stall_left = rx_idle ? $urandom_range(MAX_GAP, 0) : 0;
            else if (out_valid && stall_left > 0)
                stall_left--;
            if (hold_request > 0)
            begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            else if (hold_left > 0)
                hold_left--;
            out_stall <= (stall_left > 0) || (hold_left > 0);
        end
    end

    // Compare every taken result with the oldest owed frame, field by field.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (decoded_q.size() == 0)
            begin
                $display("%0t: result with none expected: expected nothing, actual %h %h %b",
                         $time, out_item.humidity_raw, out_item.temperature_raw,
                         out_item.checksum_ok);
                fail_count++;
            end
            else
            begin
                want = decoded_q.pop_front();
                if (out_item.humidity_raw !== want.humidity_raw)
                begin
                    $display("%0t: humidity_raw: expected %h, actual %h",
                             $time, want.humidity_raw, out_item.humidity_raw);
                    fail_count++;
                end
                if (out_item.temperature_raw !== want.temperature_raw)
                begin
                    $display("%0t: temperature_raw: expected %h, actual %h",
                             $time, want.temperature_raw, out_item.temperature_raw);
                    fail_count++;
                end
                if (out_item.checksum_ok !== want.checksum_ok)
                begin
                    $display("%0t: checksum_ok: expected %b, actual %b",
                             $time, want.checksum_ok, out_item.checksum_ok);
                    fail_count++;
                end
            end
        end
    end

    initial
    begin
        rst_n            = 1'b0;
        in_valid         = 1'b0;
        in_item          = '0;
        psel             = 1'b0;
        penable          = 1'b0;
        pwrite           = 1'b0;
        paddr            = '0;
        pwdata           = '0;
        fail_count       = 0;
        live_items       = 0;
        hold_request     = 0;
        tx_idle          = 1'b1;
        rx_idle          = 1'b1;
        // Reset values: waiting for a frame start, default windows.
        last_edge        = '0;
        edges_seen       = '0;
        shift_bits       = '0;
        frame_closed     = 1'b1;
        zero_lo          = ZERO_MIN_RESET;
        zero_hi          = ZERO_MAX_RESET;
        one_lo           = ONE_MIN_RESET;
        one_hi           = ONE_MAX_RESET;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_edges_before_start;
        test_boundary_frame;
        test_window_extremes;
        test_backpressure;
        test_random_traffic;

        // Drop valid, collect every owed frame, then allow the pipeline to settle.
        wait_drained;
        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // Guard against a hung handshake; far beyond the slowest correct run.
    initial
    begin
        #4_000_000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule

// ----- filelist.f -----
src/owsd_pkg.sv
src/one_wire_sensor_pulse_decoder_top.sv
test/one_wire_sensor_pulse_decoder_top_test.sv
